>>> src/ddwro_pkg.sv
package ddwro_pkg;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int LIN_W = 35;

  // Digit-serial multiplier: the second operand is consumed one digit a cycle
  localparam int DIG_W      = 8;
  localparam int MUL_B_W    = 40;
  localparam int MUL_DIGITS = MUL_B_W / DIG_W;

  // CORDIC datapath width (Q30 with headroom)
  localparam int ANG_W = 34;

  // Width of the saturation helper's input
  localparam int SAT_IN_W = 104;

  // Angle constants in Q30
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam int ATAN_ENTRIES = 24;

  // Configuration register indexes
  localparam logic [2:0] CFG_HALF_BASELINE = 3'd0;
  localparam logic [2:0] CFG_INV_RADIUS    = 3'd1;
  localparam logic [2:0] CFG_TICK_PERIOD   = 3'd2;
  localparam logic [2:0] CFG_GOAL_X        = 3'd3;
  localparam logic [2:0] CFG_GOAL_Y        = 3'd4;
  localparam logic [2:0] CFG_GOAL_HEADING  = 3'd5;

  // Status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // A clipped 32-bit value with its clip mark
  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(64'sd2147483647);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(-64'sd2147483648);

  // Clip a wide signed value into the 32-bit signed range.
  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
    sat_t r;
    r.clip = (v > SAT_HI) || (v < SAT_LO);
    if (v > SAT_HI) begin
      r.val = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r.val = 32'sh80000000;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Truncated atan(2^-i) in Q30.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:    r = 30'd843314856;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043836;
      5'd3:    r = 30'd133525158;
      5'd4:    r = 30'd67021686;
      5'd5:    r = 30'd33543515;
      5'd6:    r = 30'd16775850;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194282;
      5'd9:    r = 30'd2097149;
      5'd10:   r = 30'd1048575;
      5'd11:   r = 30'd524287;
      5'd12:   r = 30'd262143;
      5'd13:   r = 30'd131071;
      5'd14:   r = 30'd65535;
      5'd15:   r = 30'd32767;
      5'd16:   r = 30'd16383;
      5'd17:   r = 30'd8191;
      5'd18:   r = 30'd4095;
      5'd19:   r = 30'd2047;
      5'd20:   r = 30'd1023;
      5'd21:   r = 30'd511;
      5'd22:   r = 30'd255;
      5'd23:   r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/diff_drive_wheel_rate_odometry.sv
// Channel    Direction  Beat contents
// s_axis     in         tdata: vel_x, vel_y, turn_rate (32 bits each)
// m_axis     out        tdata: wheel rates, pose, pose error; tuser: saturated
// cfg        in         write enable, register index, write data
//
// Eight products share one multiplier that takes one 8-bit digit a cycle; the CORDIC
// adds a reduction pass and one rotation a cycle.
// Reset (synchronous) zeroes the pose and loads the register defaults.
// A finished beat waits in the output register; the next tick is taken meanwhile, and
// the sequencer holds its last state while the output register is still full.
module diff_drive_wheel_rate_odometry #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // vel_x, vel_y, turn_rate
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // left_wheel_rate, right_wheel_rate, position_x,
                                  // position_y, heading_out, error_x, error_y,
                                  // error_heading
  output logic [0:0]   m_tuser,   // saturated
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = 64 - FRAC_BITS;
  localparam int PW = AW + ddwro_pkg::MUL_B_W;
  localparam int BW = ddwro_pkg::MUL_B_W;
  localparam int SW = ddwro_pkg::SAT_IN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_DY,
    ST_DH,
    ST_POSE,
    ST_TRIG,
    ST_LIN_C,
    ST_LIN_S,
    ST_ANG,
    ST_LEFT,
    ST_RIGHT,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [30:0]        half_baseline;
  logic [23:0]        inv_wheel_radius;
  logic [15:0]        tick_period;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] goal_heading;

  // Tick operands and pose
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] w;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_h;
  logic signed [31:0] err_x;
  logic signed [31:0] err_y;
  logic signed [31:0] err_h;
  logic signed [31:0] left_rate;
  logic signed [31:0] right_rate;
  logic               clip;

  // Wheel term intermediates
  logic signed [63:0]                  prod_c;
  logic signed [ddwro_pkg::LIN_W-1:0]  lin;
  logic signed [AW-1:0]                ang;

  // Shared units
  logic                               mstart;
  logic signed [AW-1:0]               ma;
  logic signed [BW-1:0]               mb;
  logic signed [PW-1:0]               prod;
  ddwro_pkg::unit_stat_t              mstat;
  logic                               cstart;
  ddwro_pkg::unit_stat_t              cstat;
  logic signed [ddwro_pkg::ANG_W-1:0] cos_v;
  logic signed [ddwro_pkg::ANG_W-1:0] sin_v;

  // Combinational helpers
  logic signed [31:0]  delta;
  logic signed [SW-1:0] pose_sum;
  ddwro_pkg::sat_t      pose_sat;
  ddwro_pkg::sat_t      ex_sat;
  ddwro_pkg::sat_t      ey_sat;
  ddwro_pkg::sat_t      eh_sat;
  ddwro_pkg::sat_t      wheel_sat;
  logic signed [AW-1:0] ang_new;
  logic signed [AW-1:0] lin_x;
  logic signed [63:0]   lin_sum;
  logic                 out_free;

  ddwro_mul #(
    .AW(AW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mstart),
    .a    (ma),
    .b    (mb),
    .stat (mstat),
    .p    (prod)
  );

  ddwro_cordic #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cstart),
    .heading(pose_h),
    .stat   (cstat),
    .cos_v  (cos_v),
    .sin_v  (sin_v)
  );

  // Pose step: floor(vel * period / 2^16) added to the coordinate in this state.
  always_comb begin
    delta = $signed(prod[47:16]);
    unique case (state)
      ST_DX:   pose_sum = SW'(33'(pose_x) + 33'(delta));
      ST_DY:   pose_sum = SW'(33'(pose_y) + 33'(delta));
      default: pose_sum = SW'(33'(pose_h) + 33'(delta));
    endcase
    pose_sat  = ddwro_pkg::sat32(pose_sum);
    ex_sat    = ddwro_pkg::sat32(SW'(33'(pose_x) - 33'(goal_x)));
    ey_sat    = ddwro_pkg::sat32(SW'(33'(pose_y) - 33'(goal_y)));
    eh_sat    = ddwro_pkg::sat32(SW'(33'(pose_h) - 33'(goal_heading)));
    wheel_sat = ddwro_pkg::sat32(SW'(prod >>> 16));
    ang_new   = AW'(prod >>> FRAC_BITS);
    lin_x     = AW'(lin);
    lin_sum   = prod_c + $signed(prod[63:0]);
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_baseline    <= 31'd16384;
      inv_wheel_radius <= 24'd65536;
      tick_period      <= 16'd6554;
      goal_x           <= '0;
      goal_y           <= '0;
      goal_heading     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddwro_pkg::CFG_HALF_BASELINE: half_baseline    <= cfg_data[30:0];
        ddwro_pkg::CFG_INV_RADIUS:    inv_wheel_radius <= cfg_data[23:0];
        ddwro_pkg::CFG_TICK_PERIOD:   tick_period      <= cfg_data[15:0];
        ddwro_pkg::CFG_GOAL_X:        goal_x           <= cfg_data;
        ddwro_pkg::CFG_GOAL_Y:        goal_y           <= cfg_data;
        ddwro_pkg::CFG_GOAL_HEADING:  goal_heading     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mstart   <= 1'b0;
      cstart   <= 1'b0;
      m_tvalid <= 1'b0;
      pose_x   <= '0;
      pose_y   <= '0;
      pose_h   <= '0;
    end else begin
      mstart <= 1'b0;
      cstart <= 1'b0;
      // The done state reloads the output itself when the beat leaves.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            vx     <= $signed(s_tdata[31:0]);
            vy     <= $signed(s_tdata[63:32]);
            w      <= $signed(s_tdata[95:64]);
            clip   <= 1'b0;
            ma     <= AW'($signed(s_tdata[31:0]));
            mb     <= BW'(tick_period);
            mstart <= 1'b1;
            state  <= ST_DX;
          end
        end
        ST_DX: begin
          if (mstat.done) begin
            pose_x <= pose_sat.val;
            clip   <= clip | pose_sat.clip;
            ma     <= AW'(vy);
            mstart <= 1'b1;
            state  <= ST_DY;
          end
        end
        ST_DY: begin
          if (mstat.done) begin
            pose_y <= pose_sat.val;
            clip   <= clip | pose_sat.clip;
            ma     <= AW'(w);
            mstart <= 1'b1;
            state  <= ST_DH;
          end
        end
        ST_DH: begin
          if (mstat.done) begin
            pose_h <= pose_sat.val;
            clip   <= clip | pose_sat.clip;
            state  <= ST_POSE;
          end
        end
        // Pose error against the goal; the heading goes to the CORDIC.
        ST_POSE: begin
          err_x  <= ex_sat.val;
          err_y  <= ey_sat.val;
          err_h  <= eh_sat.val;
          clip   <= clip | ex_sat.clip | ey_sat.clip | eh_sat.clip;
          cstart <= 1'b1;
          state  <= ST_TRIG;
        end
        ST_TRIG: begin
          if (cstat.done) begin
            ma     <= AW'(cos_v);
            mb     <= BW'(vx);
            mstart <= 1'b1;
            state  <= ST_LIN_C;
          end
        end
        ST_LIN_C: begin
          if (mstat.done) begin
            prod_c <= $signed(prod[63:0]);
            ma     <= AW'(sin_v);
            mb     <= BW'(vy);
            mstart <= 1'b1;
            state  <= ST_LIN_S;
          end
        end
        ST_LIN_S: begin
          if (mstat.done) begin
            lin    <= ddwro_pkg::LIN_W'(lin_sum >>> 30);
            ma     <= AW'(w);
            mb     <= BW'(half_baseline);
            mstart <= 1'b1;
            state  <= ST_ANG;
          end
        end
        ST_ANG: begin
          if (mstat.done) begin
            ang    <= ang_new;
            ma     <= lin_x - ang_new;
            mb     <= BW'(inv_wheel_radius);
            mstart <= 1'b1;
            state  <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          if (mstat.done) begin
            left_rate <= wheel_sat.val;
            clip      <= clip | wheel_sat.clip;
            ma        <= lin_x + ang;
            mstart    <= 1'b1;
            state     <= ST_RIGHT;
          end
        end
        ST_RIGHT: begin
          if (mstat.done) begin
            right_rate <= wheel_sat.val;
            clip       <= clip | wheel_sat.clip;
            state      <= ST_DONE;
          end
        end
        // Hand the beat over once the output register is free.
        ST_DONE: begin
          if (out_free) begin
            m_tdata[31:0]    <= left_rate;
            m_tdata[63:32]   <= right_rate;
            m_tdata[95:64]   <= pose_x;
            m_tdata[127:96]  <= pose_y;
            m_tdata[159:128] <= pose_h;
            m_tdata[191:160] <= err_x;
            m_tdata[223:192] <= err_y;
            m_tdata[255:224] <= err_h;
            m_tuser[0]       <= clip;
            m_tvalid         <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The multiplier is only started when it is free.
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mstart |-> !mstat.busy)
    else $error("multiplier started while busy");

  // CORDIC results arrive only while the sequencer waits for them.
  a_cordic_wait: assert property (@(posedge clk) disable iff (rst)
    cstat.done |-> (state == ST_TRIG))
    else $error("CORDIC finished outside its wait state");

  // A finished tick always reaches the output register.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> m_tvalid)
    else $error("finished beat not presented");

endmodule

>>> src/ddwro_mul.sv
module ddwro_mul #(
  parameter int AW = 48
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic signed [AW-1:0]                         a,
  input  logic signed [ddwro_pkg::MUL_B_W-1:0]         b,
  output ddwro_pkg::unit_stat_t                        stat,
  output logic signed [AW+ddwro_pkg::MUL_B_W-1:0]      p
);

  localparam int PW = AW + ddwro_pkg::MUL_B_W;
  localparam int BW = ddwro_pkg::MUL_B_W;
  localparam int DW = ddwro_pkg::DIG_W;
  localparam int CW = $clog2(ddwro_pkg::MUL_DIGITS + 1);

  logic signed [AW-1:0]   a_reg;
  logic [BW-1:0]          b_sh;
  logic [CW-1:0]          cnt;
  logic signed [PW-1:0]   acc;
  logic                   done;
  logic signed [DW:0]     digit;
  logic signed [AW+DW:0]  part;

  // Most significant digit first; only the top digit carries the sign.
  always_comb begin
    if (cnt == CW'(ddwro_pkg::MUL_DIGITS)) begin
      digit = $signed({b_sh[BW-1], b_sh[BW-1 -: DW]});
    end else begin
      digit = $signed({1'b0, b_sh[BW-1 -: DW]});
    end
    part = a_reg * digit;
  end

  // Shift-and-add accumulation, one digit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        b_sh  <= b;
        acc   <= '0;
        cnt   <= CW'(ddwro_pkg::MUL_DIGITS);
      end else if (cnt != '0) begin
        acc  <= (acc <<< DW) + PW'(part);
        b_sh <= b_sh << DW;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign p         = acc;

endmodule

>>> src/ddwro_cordic.sv
module ddwro_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [31:0]                     heading,
  output ddwro_pkg::unit_stat_t                  stat,
  output logic signed [ddwro_pkg::ANG_W-1:0]     cos_v,
  output logic signed [ddwro_pkg::ANG_W-1:0]     sin_v
);

  localparam int AW        = ddwro_pkg::ANG_W;
  localparam int HW        = 62 - FRAC_BITS;
  localparam int RED_STEPS = 29 - FRAC_BITS;
  localparam int NSTEPS    = (CORDIC_STEPS < ddwro_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : ddwro_pkg::ATAN_ENTRIES;
  localparam int RCW       = $clog2(RED_STEPS + 1);
  localparam int ICW       = $clog2(NSTEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_FOLD,
    S_ROTATE,
    S_OUT
  } cstate_t;

  cstate_t               state;
  logic [HW-1:0]         mag;
  logic [HW-1:0]         divisor;
  logic                  zneg;
  logic                  flip;
  logic [RCW-1:0]        rcnt;
  logic [ICW-1:0]        iter;
  logic signed [AW-1:0]  x;
  logic signed [AW-1:0]  y;
  logic signed [AW-1:0]  z;
  logic                  done;

  logic signed [HW-1:0]  zwide;
  logic signed [35:0]    zr;
  logic signed [35:0]    zw;
  logic signed [35:0]    zf;
  logic                  fold;
  logic signed [AW-1:0]  xs;
  logic signed [AW-1:0]  ys;
  logic signed [AW-1:0]  at;

  // Heading widened to Q30 and taken apart into sign and magnitude.
  assign zwide = HW'(heading) <<< (30 - FRAC_BITS);

  // Remainder back to a signed angle, wrapped to [-pi, pi] and folded.
  always_comb begin
    zr = zneg ? -$signed({3'b0, mag[32:0]}) : $signed({3'b0, mag[32:0]});
    zw = zr;
    if (zr > $signed({3'b0, ddwro_pkg::PI_Q30})) begin
      zw = zr - $signed({3'b0, ddwro_pkg::TWO_PI_Q30});
    end else if (zr < -$signed({3'b0, ddwro_pkg::PI_Q30})) begin
      zw = zr + $signed({3'b0, ddwro_pkg::TWO_PI_Q30});
    end
    fold = 1'b0;
    zf   = zw;
    if (zw > $signed({3'b0, ddwro_pkg::HALF_PI_Q30})) begin
      zf   = zw - $signed({3'b0, ddwro_pkg::PI_Q30});
      fold = 1'b1;
    end else if (zw < -$signed({3'b0, ddwro_pkg::HALF_PI_Q30})) begin
      zf   = zw + $signed({3'b0, ddwro_pkg::PI_Q30});
      fold = 1'b1;
    end
  end

  // Shared rotation step.
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed({{(AW - 30){1'b0}}, ddwro_pkg::atan_q30(5'(iter))});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            zneg    <= zwide[HW-1];
            mag     <= zwide[HW-1] ? HW'(-zwide) : HW'(zwide);
            divisor <= HW'(ddwro_pkg::TWO_PI_Q30) << (RED_STEPS - 1);
            rcnt    <= RCW'(RED_STEPS);
            state   <= S_REDUCE;
          end
        end
        // Restoring reduction modulo 2*pi, one compare and subtract a cycle.
        S_REDUCE: begin
          if (mag >= divisor) begin
            mag <= mag - divisor;
          end
          divisor <= divisor >> 1;
          rcnt    <= rcnt - RCW'(1);
          if (rcnt == RCW'(1)) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          z     <= AW'(zf);
          flip  <= fold;
          x     <= AW'($signed({1'b0, ddwro_pkg::GAIN_Q30}));
          y     <= '0;
          iter  <= '0;
          state <= S_ROTATE;
        end
        S_ROTATE: begin
          if (!z[AW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          iter <= iter + ICW'(1);
          if (iter == ICW'(NSTEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          cos_v <= flip ? -x : x;
          sin_v <= flip ? -y : y;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam longint PI_Q   = 64'sd3373259426;
  localparam longint HPI_Q  = 64'sd1686629713;
  localparam longint TPI_Q  = 64'sd6746518852;
  localparam longint GAIN_Q = 64'sd652032874;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_TICKS   = 1830;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] left_rate;
    logic signed [31:0] right_rate;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] err_x;
    logic signed [31:0] err_y;
    logic signed [31:0] err_heading;
    logic               clipped;
  } wheel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [255:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = ddwro_pkg::CFG_HALF_BASELINE;
  logic [31:0] cfg_data = '0;

  tick_t       tick_queue[$];
  wheel_beat_t expected_beats[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          all_sent = 1'b0;

  // Predictor copy of the pose and registers.
  longint odo_x, odo_y, odo_hd;
  longint reg_hb, reg_inv_r, reg_tp, reg_gx, reg_gy, reg_gh;

  diff_drive_wheel_rate_odometry dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                      524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                      2047, 1023, 511, 255, 127};
    return t[i];
  endfunction

  // Scale by the inverse radius, clipping products beyond the 64-bit range.
  function automatic longint wheel_rate(longint a, longint b, ref bit flag);
    longint lim;
    if (b == 0) return 0;
    lim = 64'sh7FFFFFFFFFFFFFFF / b;
    if (a > lim) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (a < -lim) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return clip32(floor_shift(a * b, 16), flag);
  endfunction

  // Advance the pose by one tick and work out the wheel rates.
  function automatic wheel_beat_t odometry_step(tick_t t);
    wheel_beat_t r;
    bit flag;
    longint vx, vy, w, z, cx, cy, nx, lin, ang, ex, ey, eh;
    bit flip;
    flag = 1'b0;
    flip = 1'b0;
    vx = t.vel_x;
    vy = t.vel_y;
    w = t.turn_rate;
    odo_x = clip32(odo_x + floor_shift(vx * reg_tp, 16), flag);
    odo_y = clip32(odo_y + floor_shift(vy * reg_tp, 16), flag);
    odo_hd = clip32(odo_hd + floor_shift(w * reg_tp, 16), flag);
    ex = clip32(odo_x - reg_gx, flag);
    ey = clip32(odo_y - reg_gy, flag);
    eh = clip32(odo_hd - reg_gh, flag);
    // Reduce the heading into [-pi/2, pi/2]; a fold by pi flips both outputs.
    z = (odo_hd * 16384) % TPI_Q;
    if (z > PI_Q) z -= TPI_Q;
    if (z < -PI_Q) z += TPI_Q;
    if (z > HPI_Q) begin
      z -= PI_Q;
      flip = 1'b1;
    end else if (z < -HPI_Q) begin
      z += PI_Q;
      flip = 1'b1;
    end
    cx = GAIN_Q;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= atan_entry(i);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += atan_entry(i);
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    lin = floor_shift(cx * vx + cy * vy, 30);
    ang = floor_shift(reg_hb * w, 16);
    r.left_rate = wheel_rate(lin - ang, reg_inv_r, flag);
    r.right_rate = wheel_rate(lin + ang, reg_inv_r, flag);
    r.pos_x = odo_x;
    r.pos_y = odo_y;
    r.heading = odo_hd;
    r.err_x = ex;
    r.err_y = ey;
    r.err_heading = eh;
    r.clipped = flag;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ddwro_pkg::CFG_HALF_BASELINE: reg_hb = val[30:0];
      ddwro_pkg::CFG_INV_RADIUS:    reg_inv_r = val[23:0];
      ddwro_pkg::CFG_TICK_PERIOD:   reg_tp = val[15:0];
      ddwro_pkg::CFG_GOAL_X:        reg_gx = $signed(val);
      ddwro_pkg::CFG_GOAL_Y:        reg_gy = $signed(val);
      default:                      reg_gh = $signed(val);
    endcase
  endtask

  // Wait until every queued tick has been sent and every result checked,
  // sampling between edges so that no pending update is missed.
  task automatic drain_block();
    do @(negedge clk);
    while (tick_queue.size() != 0 || s_tvalid || expected_beats.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  // Driver: one beat per queued tick with a random gap before each.
  always @(posedge clk) begin
    tick_t nt;
    tick_t sent;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sent.vel_x = s_tdata[31:0];
        sent.vel_y = s_tdata[63:32];
        sent.turn_rate = s_tdata[95:64];
        expected_beats.push_back(odometry_step(sent));
        s_tvalid <= 1'b0;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else if (!s_tvalid) begin
        if (send_gap > 0) send_gap--;
        else if (tick_queue.size() > 0) begin
          nt = tick_queue.pop_front();
          s_tdata <= {nt.turn_rate, nt.vel_y, nt.vel_x};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk) begin
    wheel_beat_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
               m_tdata[159:128], m_tdata[191:160], m_tdata[223:192],
               m_tdata[255:224], m_tuser[0]};
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got.left_rate !== want.left_rate) begin
            $error("left_wheel_rate exp %0d got %0d", want.left_rate, got.left_rate);
            fail_count++;
          end
          if (got.right_rate !== want.right_rate) begin
            $error("right_wheel_rate exp %0d got %0d", want.right_rate, got.right_rate);
            fail_count++;
          end
          if (got.pos_x !== want.pos_x) begin
            $error("position_x exp %0d got %0d", want.pos_x, got.pos_x);
            fail_count++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("position_y exp %0d got %0d", want.pos_y, got.pos_y);
            fail_count++;
          end
          if (got.heading !== want.heading) begin
            $error("heading_out exp %0d got %0d", want.heading, got.heading);
            fail_count++;
          end
          if (got.err_x !== want.err_x) begin
            $error("error_x exp %0d got %0d", want.err_x, got.err_x);
            fail_count++;
          end
          if (got.err_y !== want.err_y) begin
            $error("error_y exp %0d got %0d", want.err_y, got.err_y);
            fail_count++;
          end
          if (got.err_heading !== want.err_heading) begin
            $error("error_heading exp %0d got %0d", want.err_heading, got.err_heading);
            fail_count++;
          end
          if (got.clipped !== want.clipped) begin
            $error("saturated exp %0d got %0d", want.clipped, got.clipped);
            fail_count++;
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        m_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= (recv_gap == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else if (!all_sent || expected_beats.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: directed extremes, then random ticks across several settings.
  initial begin
    tick_t t;
    odo_x = 0; odo_y = 0; odo_hd = 0;
    reg_hb = 16384; reg_inv_r = 65536; reg_tp = 6554;
    reg_gx = 0; reg_gy = 0; reg_gh = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tick_queue.push_back('{32'sh10000, 0, 32'sh8000});
    tick_queue.push_back('{0, 0, 0});
    tick_queue.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    tick_queue.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    tick_queue.push_back('{-1, -1, -1});
    tick_queue.push_back('{32'sh20000, 32'sh30000, 32'sh190000});
    tick_queue.push_back('{32'sh20000, -32'sh30000, 32'sh190000});
    drain_block();
    // Zero tick period and zero inverse radius, with wide extremes elsewhere.
    write_reg(ddwro_pkg::CFG_TICK_PERIOD, 0);
    write_reg(ddwro_pkg::CFG_INV_RADIUS, 0);
    write_reg(ddwro_pkg::CFG_HALF_BASELINE, 32'h7FFFFFFF);
    tick_queue.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    tick_queue.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    drain_block();
    write_reg(ddwro_pkg::CFG_TICK_PERIOD, 16'hFFFF);
    write_reg(ddwro_pkg::CFG_INV_RADIUS, 24'hFFFFFF);
    write_reg(ddwro_pkg::CFG_GOAL_X, 32'h80000000);
    write_reg(ddwro_pkg::CFG_GOAL_Y, 32'h7FFFFFFF);
    write_reg(ddwro_pkg::CFG_GOAL_HEADING, 32'h80000000);
    tick_queue.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    tick_queue.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    tick_queue.push_back('{32'sh40000, 32'sh40000, 32'sh40000});
    drain_block();
    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ddwro_pkg::CFG_HALF_BASELINE,
                ph == 0 ? 32'd0 : {1'b0, 31'($urandom)} >> $urandom_range(0, 14));
      write_reg(ddwro_pkg::CFG_INV_RADIUS,
                ph == 1 ? 32'd1 : 24'($urandom) >> $urandom_range(0, 8));
      write_reg(ddwro_pkg::CFG_TICK_PERIOD, ph == 2 ? 32'd1 : $urandom_range(1, 65535));
      write_reg(ddwro_pkg::CFG_GOAL_X, rand_word());
      write_reg(ddwro_pkg::CFG_GOAL_Y, rand_word());
      write_reg(ddwro_pkg::CFG_GOAL_HEADING, rand_word());
      for (int k = 0; k < RANDOM_TICKS / 6; k++) begin
        t.vel_x = rand_word();
        t.vel_y = rand_word();
        t.turn_rate = rand_word();
        tick_queue.push_back(t);
      end
      drain_block();
    end
    all_sent = 1'b1;
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
